@@ rtl/psfm_pkg.sv @@
package psfm_pkg;
	localparam int DEMAND_W = 16;
	localparam int PCOUNT_W = 7;
	localparam int TIME_BITS = 16;
	localparam int CAP_W = 31;
	localparam logic [CAP_W-1:0] FLOW_START = CAP_W'(1) << 30;
endpackage

@@ rtl/psfm_cap_ram.sv @@
module psfm_cap_ram #(
	parameter int AW = 14,
	parameter int DW = 31
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/preemptive_schedule_feasibility_maxflow.sv @@
// Preemptive schedule feasibility by maximum flow.
// Usage: pulse start with a task (task_start, task_demand, task_end, last_task)
// whenever busy is low; one beat per cycle while loading. A beat with last_task
// high starts the solve and busy rises the next cycle.
// Solve: clearing pass over the residual capacity memory, one entry per cycle
// (MAX_NODES x MAX_NODES = 16384 entries by default). Time points are then
// insertion-sorted in a small memory and deduplicated. Network build: source
// edges, then the first time point is read, then per interval its sink edge
// and the edges from each task that covers it. Each search dequeues nodes and
// checks up to sink+1 candidates per node; each augmenting path is walked back
// from the sink edge by edge. The final check reads the n source edges. The
// solve time grows with the clearing pass and the number of augmenting paths;
// one set is solved before the next is taken, so throughput is one set per
// solve. done pulses for one cycle with feasible as busy falls, and a new set
// may begin loading in that same cycle.
// Reset: the task count n_q returns to zero, processor_count to 1; the memories
// are not reset, and the capacity memory is cleared as part of each solve.
// The receiver cannot stall: done is a one-cycle strobe and must be taken.
// Write processor_count (cfg_we, cfg_data) only while idle; it is unchecked.
module preemptive_schedule_feasibility_maxflow #(
	parameter int MAX_NODES = 128,
	parameter int MAX_TASKS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [psfm_pkg::TIME_BITS-1:0] task_start,
	input  logic [psfm_pkg::DEMAND_W-1:0]  task_demand,
	input  logic [psfm_pkg::TIME_BITS-1:0] task_end,
	input  logic                           last_task,
	input  logic                           cfg_we,
	input  logic [psfm_pkg::PCOUNT_W-1:0]  cfg_data,
	output logic                           done,
	output logic                           feasible
);
	import psfm_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int AW = 2 * NW;
	localparam int LIM = (MAX_NODES - 1) / 3;
	localparam int CAPT = (MAX_TASKS < LIM) ? MAX_TASKS : LIM;
	localparam int TW = $clog2(CAPT + 1);
	localparam int XW = (CAPT > 1) ? $clog2(CAPT) : 1;
	localparam int PW = $clog2(2 * CAPT + 1);
	localparam int QW = $clog2(2 * CAPT);

	localparam logic [4:0] S_IDLE = 5'd0, S_CLR = 5'd1, S_SORTR = 5'd2,
		S_SORTC = 5'd3, S_DED = 5'd4, S_SRC = 5'd5, S_IV = 5'd6, S_IVT = 5'd7,
		S_BFS_INIT = 5'd8, S_BFS_POP = 5'd9, S_BFS_RD = 5'd10, S_BFS_CHK = 5'd11,
		S_AUG_RD = 5'd12, S_AUG_W1 = 5'd13, S_AUG_R2 = 5'd14, S_AUG_W2 = 5'd15,
		S_FIN_RD = 5'd16, S_FIN_CHK = 5'd17, S_DONE = 5'd18, S_VCLR = 5'd19,
		S_SORTX = 5'd20, S_DEDC = 5'd21, S_IVL = 5'd22, S_IVL2 = 5'd23,
		S_IVH = 5'd24, S_IVS = 5'd25, S_BFS_Q = 5'd26, S_BFS_B = 5'd27,
		S_AUG_P = 5'd28;

	logic [4:0] state_q;
	logic [TW-1:0] n_q;
	logic [PCOUNT_W-1:0] pcount_q;

	// task stores (register arrays, each read at one chosen address)
	logic [TIME_BITS-1:0] ts_mem [CAPT];
	logic [TIME_BITS-1:0] te_mem [CAPT];
	logic [DEMAND_W-1:0] td_mem [CAPT];
	logic [MAX_NODES-1:0] vis_q;

	// capacity memory port
	logic cm_we;
	logic [AW-1:0] cm_wa, cm_ra;
	logic [CAP_W-1:0] cm_wd, cm_rd;

	// time point, search queue, parent and bottleneck memory ports
	logic tp_we, q_we, p_we, b_we;
	logic [QW-1:0] tp_wa, tp_ra;
	logic [TIME_BITS-1:0] tp_wd, tp_rd;
	logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;
	logic [NW-1:0] p_wa, p_ra, p_wd, p_rd;
	logic [NW-1:0] b_wa, b_ra;
	logic [CAP_W-1:0] b_wd, b_rd;

	psfm_cap_ram #(.AW(AW), .DW(CAP_W)) u_cap (
		.clk(clk), .we(cm_we), .waddr(cm_wa), .wdata(cm_wd),
		.raddr(cm_ra), .rdata(cm_rd)
	);

	psfm_cap_ram #(.AW(QW), .DW(TIME_BITS)) u_tp (
		.clk(clk), .we(tp_we), .waddr(tp_wa), .wdata(tp_wd),
		.raddr(tp_ra), .rdata(tp_rd)
	);

	psfm_cap_ram #(.AW(NW), .DW(NW)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
		.raddr(q_ra), .rdata(q_rd)
	);

	psfm_cap_ram #(.AW(NW), .DW(NW)) u_par (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
		.raddr(p_ra), .rdata(p_rd)
	);

	psfm_cap_ram #(.AW(NW), .DW(CAP_W)) u_bot (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd),
		.raddr(b_ra), .rdata(b_rd)
	);

	logic [AW:0] cnt_q;
	logic [PW-1:0] i_q, j_q, pts_q, dist_q;
	logic [TIME_BITS-1:0] x_q, lo_q, hi_q, last_q;
	logic [TW:0] t_q;
	logic [NW-1:0] sink_q, u_q, v_q, w_q, head_q, tail_q;
	logic [NW:0] scan_q;
	logic [CAP_W-1:0] f_q, bu_q;
	logic feas_q, done_q;

	// decisions on the memory read data
	logic sort_shift, ded_new, bfs_hit;
	logic [CAP_W-1:0] bfs_min;
	assign sort_shift = (j_q != '0) && (tp_rd > x_q);
	assign ded_new = (dist_q == '0) || (last_q != tp_rd);
	assign bfs_hit = !vis_q[v_q] && (cm_rd != '0);
	assign bfs_min = (cm_rd < bu_q) ? cm_rd : bu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			pcount_q <= PCOUNT_W'(1);
			done_q <= 1'b0;
			feas_q <= 1'b0;
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			pts_q <= '0;
			dist_q <= '0;
			x_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			last_q <= '0;
			t_q <= '0;
			sink_q <= '0;
			u_q <= '0;
			v_q <= '0;
			w_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			scan_q <= '0;
			f_q <= '0;
			bu_q <= '0;
			vis_q <= '0;
		end else begin
			done_q <= (state_q == S_DONE);
			if (cfg_we)
				pcount_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (n_q < TW'(CAPT)) begin
							n_q <= n_q + 1'b1;
						end
						if (last_task) begin
							state_q <= S_CLR;
							cnt_q <= '0;
						end
					end
				end
				S_CLR: begin
					// clearing pass over the whole matrix, plus point gathering
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (AW+1)'((1 << AW) - 1)) begin
						state_q <= S_SORTR;
						pts_q <= PW'(2 * n_q);
						i_q <= PW'(1);
					end
				end
				S_SORTR: begin
					if (i_q >= pts_q) begin
						state_q <= S_DED;
						j_q <= '0;
						dist_q <= '0;
					end else begin
						j_q <= i_q;
						state_q <= S_SORTX;
					end
				end
				S_SORTX: begin
					x_q <= tp_rd;
					state_q <= S_SORTC;
				end
				S_SORTC: begin
					if (sort_shift) begin
						j_q <= j_q - 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_SORTR;
					end
				end
				S_DED: begin
					if (j_q >= pts_q) begin
						state_q <= S_SRC;
						t_q <= '0;
						sink_q <= NW'(n_q + ((dist_q != '0) ? dist_q - 1'b1 : '0) + 1'b1);
					end else
						state_q <= S_DEDC;
				end
				S_DEDC: begin
					if (ded_new) begin
						dist_q <= dist_q + 1'b1;
						last_q <= tp_rd;
					end
					j_q <= j_q + 1'b1;
					state_q <= S_DED;
				end
				S_SRC: begin
					if (t_q == (TW+1)'(n_q)) begin
						state_q <= S_IVL;
						j_q <= '0;
						t_q <= '0;
					end else
						t_q <= t_q + 1'b1;
				end
				S_IVL: state_q <= S_IVL2;
				S_IVL2: begin
					// first point becomes the low end of interval zero
					hi_q <= tp_rd;
					state_q <= S_IV;
				end
				S_IV: begin
					if (PW'(j_q + 1'b1) >= dist_q || dist_q == '0) begin
						state_q <= S_BFS_INIT;
					end else begin
						lo_q <= hi_q;
						state_q <= S_IVH;
					end
				end
				S_IVH: begin
					hi_q <= tp_rd;
					state_q <= S_IVS;
				end
				S_IVS: begin
					t_q <= '0;
					state_q <= S_IVT;
				end
				S_IVT: begin
					if (t_q == (TW+1)'(n_q)) begin
						j_q <= j_q + 1'b1;
						state_q <= S_IV;
					end else
						t_q <= t_q + 1'b1;
				end
				S_BFS_INIT: begin
					vis_q <= MAX_NODES'(1);
					head_q <= '0;
					tail_q <= NW'(1);
					state_q <= S_BFS_POP;
				end
				S_BFS_POP: begin
					if (head_q == tail_q) begin
						state_q <= S_FIN_RD;
						t_q <= (TW+1)'(1);
					end else
						state_q <= S_BFS_Q;
				end
				S_BFS_Q: begin
					u_q <= q_rd;
					head_q <= head_q + 1'b1;
					state_q <= S_BFS_B;
				end
				S_BFS_B: begin
					bu_q <= b_rd;
					scan_q <= '0;
					state_q <= S_BFS_RD;
				end
				S_BFS_RD: begin
					v_q <= NW'(scan_q);
					state_q <= S_BFS_CHK;
				end
				S_BFS_CHK: begin
					if (bfs_hit) begin
						vis_q[v_q] <= 1'b1;
						if (v_q == sink_q) begin
							f_q <= bfs_min;
							w_q <= sink_q;
							state_q <= S_AUG_RD;
						end else
							tail_q <= tail_q + 1'b1;
					end
					if (!(bfs_hit && v_q == sink_q)) begin
						if (v_q == sink_q)
							state_q <= S_BFS_POP;
						else begin
							scan_q <= scan_q + 1'b1;
							state_q <= S_BFS_RD;
						end
					end
				end
				S_AUG_RD: begin
					if (w_q == '0)
						state_q <= S_BFS_INIT;
					else
						state_q <= S_AUG_P;
				end
				S_AUG_P: begin
					u_q <= p_rd;
					state_q <= S_AUG_W1;
				end
				S_AUG_W1: state_q <= S_AUG_R2;
				S_AUG_R2: state_q <= S_AUG_W2;
				S_AUG_W2: begin
					w_q <= u_q;
					state_q <= S_AUG_RD;
				end
				S_FIN_RD: begin
					if (t_q > (TW+1)'(n_q)) begin
						feas_q <= 1'b1;
						state_q <= S_DONE;
					end else
						state_q <= S_FIN_CHK;
				end
				S_FIN_CHK: begin
					if (cm_rd != '0) begin
						feas_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						t_q <= t_q + 1'b1;
						state_q <= S_FIN_RD;
					end
				end
				S_DONE: begin
					n_q <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload stores
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && n_q < TW'(CAPT)) begin
			ts_mem[n_q[XW-1:0]] <= task_start;
			te_mem[n_q[XW-1:0]] <= task_end;
			td_mem[n_q[XW-1:0]] <= task_demand;
		end
	end

	// interval node and length
	logic [NW-1:0] iv_node;
	logic [TIME_BITS-1:0] iv_len;
	logic [XW-1:0] tix;
	logic [CAP_W-1:0] sink_cap;
	assign iv_node = NW'(n_q + 1'b1 + j_q);
	assign iv_len = hi_q - lo_q;
	assign tix = t_q[XW-1:0];
	assign sink_cap = CAP_W'(iv_len) * CAP_W'(pcount_q);

	// time point memory: gather, insertion sort, dedup, interval ends
	always_comb begin
		tp_we = 1'b0;
		tp_wa = '0;
		tp_wd = '0;
		tp_ra = '0;
		unique case (state_q)
			S_CLR: begin
				if (cnt_q < (AW+1)'(2 * n_q)) begin
					tp_we = 1'b1;
					tp_wa = QW'(cnt_q);
					tp_wd = cnt_q[0] ? te_mem[cnt_q[XW:1]] : ts_mem[cnt_q[XW:1]];
				end
			end
			S_SORTR: tp_ra = QW'(i_q);
			S_SORTX: tp_ra = QW'(j_q - 1'b1);
			S_SORTC: begin
				tp_we = 1'b1;
				tp_wa = QW'(j_q);
				tp_wd = sort_shift ? tp_rd : x_q;
				tp_ra = QW'(j_q - 2'd2);
			end
			S_DED: tp_ra = QW'(j_q);
			S_DEDC: begin
				if (ded_new) begin
					tp_we = 1'b1;
					tp_wa = QW'(dist_q);
					tp_wd = tp_rd;
				end
			end
			S_IVL: tp_ra = '0;
			S_IV: tp_ra = QW'(j_q + 1'b1);
			default: ;
		endcase
	end

	// search queue, parent and bottleneck memories
	always_comb begin
		q_we = 1'b0;
		q_wa = '0;
		q_wd = '0;
		q_ra = '0;
		p_we = 1'b0;
		p_wa = '0;
		p_wd = '0;
		p_ra = '0;
		b_we = 1'b0;
		b_wa = '0;
		b_wd = '0;
		b_ra = '0;
		unique case (state_q)
			S_BFS_INIT: begin
				q_we = 1'b1;
				b_we = 1'b1;
				b_wd = FLOW_START;
			end
			S_BFS_POP: q_ra = head_q;
			S_BFS_Q: b_ra = q_rd;
			S_BFS_CHK: begin
				if (bfs_hit) begin
					p_we = 1'b1;
					p_wa = v_q;
					p_wd = u_q;
					b_we = 1'b1;
					b_wa = v_q;
					b_wd = bfs_min;
					if (v_q != sink_q) begin
						q_we = 1'b1;
						q_wa = tail_q;
						q_wd = v_q;
					end
				end
			end
			S_AUG_RD: p_ra = w_q;
			default: ;
		endcase
	end

	// capacity memory port control
	always_comb begin
		cm_we = 1'b0;
		cm_wa = '0;
		cm_wd = '0;
		cm_ra = '0;
		unique case (state_q)
			S_CLR: begin
				cm_we = 1'b1;
				cm_wa = cnt_q[AW-1:0];
			end
			S_SRC: begin
				if (t_q != (TW+1)'(n_q)) begin
					cm_we = 1'b1;
					cm_wa = {NW'(0), NW'(t_q + 1'b1)};
					cm_wd = CAP_W'(td_mem[tix]);
				end
			end
			S_IVS: begin
				cm_we = 1'b1;
				cm_wa = {iv_node, sink_q};
				cm_wd = sink_cap;
			end
			S_IVT: begin
				if (t_q != (TW+1)'(n_q) && ts_mem[tix] <= lo_q && te_mem[tix] >= hi_q) begin
					cm_we = 1'b1;
					cm_wa = {NW'(t_q + 1'b1), iv_node};
					cm_wd = CAP_W'(iv_len);
				end
			end
			S_BFS_RD: cm_ra = {u_q, NW'(scan_q)};
			S_AUG_P: cm_ra = {p_rd, w_q};
			S_AUG_W1: begin
				cm_we = 1'b1;
				cm_wa = {u_q, w_q};
				cm_wd = cm_rd - f_q;
				cm_ra = {w_q, u_q};
			end
			S_AUG_R2: cm_ra = {w_q, u_q};
			S_AUG_W2: begin
				cm_we = 1'b1;
				cm_wa = {w_q, u_q};
				cm_wd = cm_rd + f_q;
			end
			S_FIN_RD: cm_ra = {NW'(0), NW'(t_q)};
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign feasible = feas_q;
endmodule
